// ===== hw/rtl/lpu_pkg.sv =====
`timescale 1ns / 1ps
// Package for the lens point undistortion block: fixed-point types, constants,
// configuration register indexes and saturation helpers. No dependencies.
package lpu_pkg;

  localparam int QF  = 28;
  localparam int QW  = 32;
  localparam int LOW = QW - QF;

  typedef logic signed [QW-1:0] q_t;
  typedef logic signed [35:0]   qp_t;
  typedef logic signed [19:0]   pix_t;
  typedef logic [2:0]           cfg_idx_t;

  localparam q_t Q_MAX = 32'sh7fff_ffff;
  localparam q_t Q_MIN = 32'sh8000_0000;
  localparam logic signed [63:0] S64_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S64_MIN = -64'sd2147483648;
  localparam logic signed [32:0] ONE33 = 33'sd268435456;
  localparam logic signed [49:0] HALF50 = 50'sd134217728;
  localparam logic signed [49:0] PIX_MAX50 = 50'sd524287;
  localparam logic signed [49:0] PIX_MIN50 = -50'sd524288;
  localparam pix_t PIX_MAX = 20'sd524287;
  localparam pix_t PIX_MIN = -20'sd524288;

  localparam cfg_idx_t CFG_CENTER = 3'd0;
  localparam cfg_idx_t CFG_FOCAL  = 3'd1;
  localparam cfg_idx_t CFG_K1     = 3'd2;
  localparam cfg_idx_t CFG_K2     = 3'd3;
  localparam cfg_idx_t CFG_K3     = 3'd4;
  localparam cfg_idx_t CFG_P1     = 3'd5;
  localparam cfg_idx_t CFG_P2     = 3'd6;

  localparam logic [31:0] FOCAL_RST = 32'h0010_0010;

  function automatic q_t sat32(input logic signed [63:0] v);
    q_t r;
    if (v > S64_MAX) r = Q_MAX;
    else if (v < S64_MIN) r = Q_MIN;
    else r = q_t'(v);
    return r;
  endfunction

  function automatic q_t sat_quo(input logic [QW-1:0] q, input logic ovf, input logic neg);
    q_t r;
    if (!neg) r = (ovf || q[QW-1]) ? Q_MAX : q_t'(q);
    else r = (ovf || q > 32'h8000_0000) ? Q_MIN : q_t'(-q);
    return r;
  endfunction

  function automatic pix_t sat_pix(input logic signed [49:0] v);
    pix_t r;
    if (v > PIX_MAX50) r = PIX_MAX;
    else if (v < PIX_MIN50) r = PIX_MIN;
    else r = pix_t'(v);
    return r;
  endfunction

endpackage

// ===== hw/rtl/lpu_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the point input and the result output.
// No dependencies.
interface lpu_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] point_x;
  logic [15:0] point_y;
  logic        last_point;
  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

interface lpu_out_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] undistorted_x;
  logic signed [19:0] undistorted_y;
  logic               last_point_out;
  modport source (output valid, undistorted_x, undistorted_y, last_point_out, input ready);
  modport sink (input valid, undistorted_x, undistorted_y, last_point_out, output ready);
endinterface

// ===== hw/rtl/lpu_div.sv =====
`timescale 1ns / 1ps
// Pipelined two-lane divider computing saturated (a * 2^28) / b, one quotient bit per stage.
// Depends on lpu_pkg.
module lpu_div #(
  parameter int WA = 16,
  parameter int WB = 16,
  parameter int WS = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [WA-1:0]         a_x,
  input  logic [WA-1:0]         a_y,
  input  logic [WB-1:0]         b_x,
  input  logic [WB-1:0]         b_y,
  input  logic                  neg_x,
  input  logic                  neg_y,
  input  logic [WS-1:0]         side_in,
  output logic                  out_valid,
  output lpu_pkg::q_t           q_x,
  output lpu_pkg::q_t           q_y,
  output logic [WS-1:0]         side_out
);
  import lpu_pkg::*;

  localparam int STEPS = QW;
  localparam int WC = (WA > WB + LOW) ? WA : WB + LOW;

  logic [STEPS:0]  vld_r;
  logic [STEPS:0]  ox_r, oy_r, nx_r, ny_r;
  logic [WB-1:0]   rx_r [STEPS+1];
  logic [WB-1:0]   ry_r [STEPS+1];
  logic [WB-1:0]   bx_r [STEPS+1];
  logic [WB-1:0]   by_r [STEPS+1];
  logic [LOW-1:0]  lx_r [STEPS+1];
  logic [LOW-1:0]  ly_r [STEPS+1];
  logic [QW-1:0]   qx_r [STEPS+1];
  logic [QW-1:0]   qy_r [STEPS+1];
  logic [WS-1:0]   sd_r [STEPS+1];
  logic            out_vld_r;
  q_t              qx_o_r, qy_o_r;
  logic [WS-1:0]   sd_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ox_r[0] <= (WC'(a_x) >= WC'({b_x, LOW'(0)})) && (a_x != '0);
      oy_r[0] <= (WC'(a_y) >= WC'({b_y, LOW'(0)})) && (a_y != '0);
      nx_r[0] <= neg_x;
      ny_r[0] <= neg_y;
      rx_r[0] <= WB'(a_x >> LOW);
      ry_r[0] <= WB'(a_y >> LOW);
      lx_r[0] <= a_x[LOW-1:0];
      ly_r[0] <= a_y[LOW-1:0];
      bx_r[0] <= b_x;
      by_r[0] <= b_y;
      qx_r[0] <= '0;
      qy_r[0] <= '0;
      sd_r[0] <= side_in;
    end
  end

  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    logic [WB:0] tx, ty;
    logic        gx, gy;

    assign tx = {rx_r[k-1], lx_r[k-1][LOW-1]};
    assign ty = {ry_r[k-1], ly_r[k-1][LOW-1]};
    assign gx = (tx >= {1'b0, bx_r[k-1]}) && (bx_r[k-1] != '0);
    assign gy = (ty >= {1'b0, by_r[k-1]}) && (by_r[k-1] != '0);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rx_r[k] <= gx ? WB'(tx - {1'b0, bx_r[k-1]}) : tx[WB-1:0];
        ry_r[k] <= gy ? WB'(ty - {1'b0, by_r[k-1]}) : ty[WB-1:0];
        qx_r[k] <= {qx_r[k-1][QW-2:0], gx};
        qy_r[k] <= {qy_r[k-1][QW-2:0], gy};
        lx_r[k] <= {lx_r[k-1][LOW-2:0], 1'b0};
        ly_r[k] <= {ly_r[k-1][LOW-2:0], 1'b0};
        bx_r[k] <= bx_r[k-1];
        by_r[k] <= by_r[k-1];
        ox_r[k] <= ox_r[k-1];
        oy_r[k] <= oy_r[k-1];
        nx_r[k] <= nx_r[k-1];
        ny_r[k] <= ny_r[k-1];
        sd_r[k] <= sd_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qx_o_r <= sat_quo(qx_r[STEPS], ox_r[STEPS], nx_r[STEPS]);
      qy_o_r <= sat_quo(qy_r[STEPS], oy_r[STEPS], ny_r[STEPS]);
      sd_o_r <= sd_r[STEPS];
    end
  end

  assign out_valid = out_vld_r;
  assign q_x = qx_o_r;
  assign q_y = qy_o_r;
  assign side_out = sd_o_r;

endmodule

// ===== hw/rtl/lens_point_undistort.sv =====
`timescale 1ns / 1ps
// Top level of the lens point undistortion pipeline: normalization, iterative
// distortion removal and mapping back to pixels. Depends on lpu_pkg, lpu_if, lpu_div.
//
//   Port     Direction  Handshake    Content
//   in_ch    sink       valid/ready  point_x, point_y, last_point
//   out_ch   source     valid/ready  undistorted_x, undistorted_y, last_point_out
//   cfg_*    input      write enable register index and 32-bit data
//
// One point is taken every cycle unless the output stalls. A result passes the
// input registers, the normalization divider, per iteration nine arithmetic
// stages and a divider, then output registers; each divider has 34 stages.
// Synchronous active-low reset clears valid bits and configuration except focal.
// When a result waits at the output the whole pipeline holds, so nothing is lost.
module lens_point_undistort #(
  parameter int ITERATIONS = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  lpu_in_if.sink               in_ch,
  lpu_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  lpu_pkg::cfg_idx_t    cfg_idx,
  input  logic [31:0]          cfg_data
);
  import lpu_pkg::*;

  localparam int SD = 2 * QW + 1;

  logic [31:0] center_r, focal_r;
  q_t          k1_r, k2_r, k3_r, p1_r, p2_r;
  logic        en;
  logic [15:0] fx_eff, fy_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= '0;
      focal_r  <= FOCAL_RST;
      k1_r     <= '0;
      k2_r     <= '0;
      k3_r     <= '0;
      p1_r     <= '0;
      p2_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_CENTER: center_r <= cfg_data;
        CFG_FOCAL:  focal_r  <= cfg_data;
        CFG_K1:     k1_r     <= q_t'(cfg_data);
        CFG_K2:     k2_r     <= q_t'(cfg_data);
        CFG_K3:     k3_r     <= q_t'(cfg_data);
        CFG_P1:     p1_r     <= q_t'(cfg_data);
        CFG_P2:     p2_r     <= q_t'(cfg_data);
        default: ;
      endcase
    end
  end

  assign fx_eff = (focal_r[15:0] == '0) ? 16'd1 : focal_r[15:0];
  assign fy_eff = (focal_r[31:16] == '0) ? 16'd1 : focal_r[31:16];

  logic out_vld_r;
  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // Input capture and normalization setup.
  logic        n0_vld_r, n0_last_r;
  logic [15:0] n0_px_r, n0_py_r;
  logic        n1_vld_r, n1_last_r, n1_nx_r, n1_ny_r;
  logic [15:0] n1_ax_r, n1_ay_r, n1_bx_r, n1_by_r;
  logic signed [16:0] ddx, ddy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n0_vld_r <= 1'b0;
      n1_vld_r <= 1'b0;
    end else if (en) begin
      n0_vld_r <= in_ch.valid;
      n1_vld_r <= n0_vld_r;
    end
  end

  assign ddx = signed'({1'b0, n0_px_r}) - signed'({1'b0, center_r[15:0]});
  assign ddy = signed'({1'b0, n0_py_r}) - signed'({1'b0, center_r[31:16]});

  always_ff @(posedge clk) begin
    if (en) begin
      n0_px_r   <= in_ch.point_x;
      n0_py_r   <= in_ch.point_y;
      n0_last_r <= in_ch.last_point;
      n1_ax_r   <= ddx[16] ? 16'(-ddx) : ddx[15:0];
      n1_ay_r   <= ddy[16] ? 16'(-ddy) : ddy[15:0];
      n1_nx_r   <= ddx[16];
      n1_ny_r   <= ddy[16];
      n1_bx_r   <= fx_eff;
      n1_by_r   <= fy_eff;
      n1_last_r <= n0_last_r;
    end
  end

  logic it_vld  [ITERATIONS+1];
  logic it_last [ITERATIONS+1];
  q_t   it_x    [ITERATIONS+1];
  q_t   it_y    [ITERATIONS+1];
  q_t   it_x0   [ITERATIONS+1];
  q_t   it_y0   [ITERATIONS+1];
  logic n_last;

  lpu_div #(.WA(16), .WB(16), .WS(1)) u_norm (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(n1_vld_r),
    .a_x(n1_ax_r), .a_y(n1_ay_r), .b_x(n1_bx_r), .b_y(n1_by_r),
    .neg_x(n1_nx_r), .neg_y(n1_ny_r), .side_in(n1_last_r),
    .out_valid(it_vld[0]), .q_x(it_x[0]), .q_y(it_y[0]), .side_out(n_last)
  );

  assign it_last[0] = n_last;
  assign it_x0[0]   = it_x[0];
  assign it_y0[0]   = it_y[0];

  for (genvar g = 0; g < ITERATIONS; g++) begin : g_iter
    logic [8:0]    v_r;
    logic [SD-1:0] sd_r [9];
    logic [SD-1:0] sd_o;
    logic signed [63:0] pxx, pyy, pxy, pm1, pxp1, pxp2, pdxa, pdyb, pm2, pm3;
    q_t  a_xx_r, a_yy_r, a_xy_r;
    q_t  b_xx_r, b_yy_r, b_xy_r, b_r2_r;
    qp_t c_m1_r, c_xp1_r, c_xp2_r;
    q_t  c_ux_r, c_uy_r, c_r2_r;
    q_t  d_t1_r, d_r2_r;
    qp_t d_dxa_r, d_dyb_r, d_xp1_r, d_xp2_r;
    qp_t e_m2_r;
    q_t  e_dx_r, e_dy_r, e_r2_r;
    q_t  f_t2_r, f_r2_r, f_dx_r, f_dy_r;
    qp_t g_m3_r;
    q_t  g_dx_r, g_dy_r;
    logic signed [32:0] h_den_r, h_nx_r, h_ny_r;
    logic [32:0] i_ax_r, i_ay_r, i_b_r;
    logic        i_nx_r, i_ny_r;

    assign pxx  = it_x[g] * it_x[g];
    assign pyy  = it_y[g] * it_y[g];
    assign pxy  = it_x[g] * it_y[g];
    assign pm1  = k3_r * b_r2_r;
    assign pxp1 = p1_r * b_xy_r;
    assign pxp2 = p2_r * b_xy_r;
    assign pdxa = p2_r * c_ux_r;
    assign pdyb = p1_r * c_uy_r;
    assign pm2  = d_t1_r * d_r2_r;
    assign pm3  = f_t2_r * f_r2_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= '0;
      end else if (en) begin
        v_r <= {v_r[7:0], it_vld[g]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd_r[0] <= {it_x0[g], it_y0[g], it_last[g]};
        for (int s = 1; s < 9; s++) begin
          sd_r[s] <= sd_r[s-1];
        end
        a_xx_r  <= sat32(pxx >>> QF);
        a_yy_r  <= sat32(pyy >>> QF);
        a_xy_r  <= sat32(pxy >>> QF);
        b_xx_r  <= a_xx_r;
        b_yy_r  <= a_yy_r;
        b_xy_r  <= a_xy_r;
        b_r2_r  <= sat32(64'(a_xx_r) + 64'(a_yy_r));
        c_m1_r  <= qp_t'(pm1 >>> QF);
        c_xp1_r <= qp_t'(pxp1 >>> QF);
        c_xp2_r <= qp_t'(pxp2 >>> QF);
        c_ux_r  <= sat32(64'(b_r2_r) + (64'(b_xx_r) <<< 1));
        c_uy_r  <= sat32(64'(b_r2_r) + (64'(b_yy_r) <<< 1));
        c_r2_r  <= b_r2_r;
        d_t1_r  <= sat32(64'(c_m1_r) + 64'(k2_r));
        d_dxa_r <= qp_t'(pdxa >>> QF);
        d_dyb_r <= qp_t'(pdyb >>> QF);
        d_xp1_r <= c_xp1_r;
        d_xp2_r <= c_xp2_r;
        d_r2_r  <= c_r2_r;
        e_m2_r  <= qp_t'(pm2 >>> QF);
        e_dx_r  <= sat32((64'(d_xp1_r) <<< 1) + 64'(d_dxa_r));
        e_dy_r  <= sat32(64'(d_dyb_r) + (64'(d_xp2_r) <<< 1));
        e_r2_r  <= d_r2_r;
        f_t2_r  <= sat32(64'(e_m2_r) + 64'(k1_r));
        f_r2_r  <= e_r2_r;
        f_dx_r  <= e_dx_r;
        f_dy_r  <= e_dy_r;
        g_m3_r  <= qp_t'(pm3 >>> QF);
        g_dx_r  <= f_dx_r;
        g_dy_r  <= f_dy_r;
        h_den_r <= ONE33 + 33'(sat32(64'(g_m3_r)));
        h_nx_r  <= 33'(signed'(sd_r[6][SD-1:QW+1])) - 33'(g_dx_r);
        h_ny_r  <= 33'(signed'(sd_r[6][QW:1])) - 33'(g_dy_r);
        i_ax_r  <= h_nx_r[32] ? 33'(-h_nx_r) : 33'(h_nx_r);
        i_ay_r  <= h_ny_r[32] ? 33'(-h_ny_r) : 33'(h_ny_r);
        i_b_r   <= h_den_r[32] ? 33'(-h_den_r) : 33'(h_den_r);
        i_nx_r  <= h_nx_r[32] ^ h_den_r[32];
        i_ny_r  <= h_ny_r[32] ^ h_den_r[32];
      end
    end

    lpu_div #(.WA(33), .WB(33), .WS(SD)) u_div (
      .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v_r[8]),
      .a_x(i_ax_r), .a_y(i_ay_r), .b_x(i_b_r), .b_y(i_b_r),
      .neg_x(i_nx_r), .neg_y(i_ny_r), .side_in(sd_r[8]),
      .out_valid(it_vld[g+1]), .q_x(it_x[g+1]), .q_y(it_y[g+1]), .side_out(sd_o)
    );

    assign it_x0[g+1]   = q_t'(sd_o[SD-1:QW+1]);
    assign it_y0[g+1]   = q_t'(sd_o[QW:1]);
    assign it_last[g+1] = sd_o[0];
  end

  // Mapping back to pixels.
  logic               p1_vld_r, p1_last_r;
  logic signed [48:0] p1_px_r, p1_py_r;
  logic signed [48:0] prx, pry;
  logic signed [49:0] sx, sy;
  pix_t               out_x_r, out_y_r;
  logic               out_last_r;

  assign prx = it_x[ITERATIONS] * signed'({1'b0, fx_eff});
  assign pry = it_y[ITERATIONS] * signed'({1'b0, fy_eff});
  assign sx = ((50'(p1_px_r) + HALF50) >>> QF) + 50'(signed'({1'b0, center_r[15:0]}));
  assign sy = ((50'(p1_py_r) + HALF50) >>> QF) + 50'(signed'({1'b0, center_r[31:16]}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r  <= it_vld[ITERATIONS];
      out_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_px_r    <= prx;
      p1_py_r    <= pry;
      p1_last_r  <= it_last[ITERATIONS];
      out_x_r    <= sat_pix(sx);
      out_y_r    <= sat_pix(sy);
      out_last_r <= p1_last_r;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.undistorted_x  = out_x_r;
  assign out_ch.undistorted_y  = out_y_r;
  assign out_ch.last_point_out = out_last_r;

`ifndef SYNTHESIS
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_vld_r && !n0_vld_r && !p1_vld_r)
    else $error("pipeline valid bits not cleared by reset");
  a_rst_focal: assert property (@(posedge clk) !rst_n |=> focal_r == FOCAL_RST)
    else $error("focal register lost its reset value");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(p1_vld_r) && $stable(n0_vld_r))
    else $error("pipeline advanced while the output was stalled");
  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> n0_vld_r)
    else $error("accepted point not captured");
`endif

endmodule
